// ===== src/spa_pkg.sv =====
// Shared types, codes and constants of the slot pool allocator.
package spa_pkg;

    localparam int SLOTS_DEF        = 256;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int POOLS_DEF        = 4;

    localparam int CAP_REGS = 4;
    localparam int CAP_W    = 9;
    localparam int CFG_IW   = 2;
    localparam int POOL_W   = 2;
    localparam int SLOT_W   = 8;
    localparam int PAY_W    = 64;
    localparam int EXT_W    = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_SET    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic [POOL_W-1:0]  pool;
        logic [SLOT_W-1:0]  slot_index;
        logic [PAY_W-1:0]   payload_in;
    } t_cmd;

    typedef struct packed {
        logic               ok;
        logic [SLOT_W-1:0]  assigned_slot;
        logic [PAY_W-1:0]   payload_out;
        logic [EXT_W-1:0]   used_extent;
    } t_rsp;

endpackage

// ===== src/spa_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module spa_ram
    import spa_pkg::*;
#(
    parameter int AW = POOL_W + SLOT_W,
    parameter int DW = PAY_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/slot_pool_allocator_core.sv =====
// Slot pool allocator top level: sequencer, pool registers and the two RAMs.
//
//  channel   | handshake                 | word
//  ----------+---------------------------+-------------------------------
//  command   | start in, busy out        | i_cmd  (mode, pool, slot, data)
//  result    | o_done strobe out         | o_rsp  (ok, slot, data, extent)
//  config    | i_cfg_we in               | i_cfg_idx, i_cfg_data
//
//  Add, remove, lookup and a direct set read the slot and free-stack RAMs with
//  start and update them in ST_EXEC; the result word is registered and follows in the next cycle.
//  A set that claims a freed slot scans the free stack through its single read
//  port, one entry per cycle.
//  After reset the slot RAM is swept to clear the active bits, one entry per
//  cycle, over 2**(pool bits + slot bits) entries, 1024 with default parameters.
//  busy stays high meanwhile. The receiver cannot stall; o_done lasts one cycle.
module slot_pool_allocator_core
    import spa_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    parameter int POOLS        = POOLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_cmd              i_cmd,
    output logic              o_done,
    output t_rsp              o_rsp,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CAP_W-1:0]  i_cfg_data
);

    localparam int SW  = $clog2(SLOTS);
    localparam int EW  = $clog2(SLOTS + 1);
    localparam int XW  = (EW > CAP_W) ? EW : CAP_W;
    localparam int PW  = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int NP  = 1 << PW;
    localparam int AW  = PW + SW;
    localparam int SDW = PAYLOAD_BITS + 1;

    localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);
    localparam logic [EW-1:0] SLOTS_E = EW'(SLOTS);
    localparam logic [EW-1:0] ONE_E   = EW'(1);

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr, n_clr;
    logic [SW-1:0]           r_i, n_i;
    logic                    r_done, n_done;
    t_rsp                    r_rsp, n_rsp;

    t_mode                   r_mode;
    logic [PW-1:0]           r_pool;
    logic                    r_pool_ok;
    logic [SLOT_W-1:0]       r_idx;
    logic [PAYLOAD_BITS-1:0] r_data;
    logic [XW-1:0]           r_cap;
    logic [SW-1:0]           r_top_ent;

    logic [CAP_W-1:0]        r_cap_cfg  [CAP_REGS];
    logic [EW-1:0]           r_extent   [NP];
    logic [EW-1:0]           r_free_top [NP];

    logic                    ext_we, top_we;
    logic [EW-1:0]           n_ext, n_top;

    logic                    slot_we;
    logic [AW-1:0]           slot_waddr, slot_raddr;
    logic [SDW-1:0]          slot_wdata, slot_rdata;
    logic                    stk_we;
    logic [AW-1:0]           stk_waddr, stk_raddr;
    logic [SW-1:0]           stk_wdata, stk_rdata;

    logic [PW-1:0]           in_pool;
    logic                    in_pool_ok;
    logic [CAP_W-1:0]        cap_raw;
    logic [XW-1:0]           cap_eff;
    logic [EW-1:0]           cur_ext, cur_top;
    logic [XW-1:0]           idx_x;
    logic [SW-1:0]           idx_s;
    logic                    in_cap, below_ext, act;
    logic [PAYLOAD_BITS-1:0] rpay;

    assign in_pool    = PW'(i_cmd.pool);
    assign in_pool_ok = 32'(i_cmd.pool) < POOLS;
    assign cap_raw    = r_cap_cfg[i_cmd.pool];
    assign cap_eff    = (XW'(cap_raw) > SLOTS_X) ? SLOTS_X : XW'(cap_raw);

    assign cur_ext   = r_extent[r_pool];
    assign cur_top   = r_free_top[r_pool];
    assign idx_x     = XW'(r_idx);
    assign idx_s     = SW'(r_idx);
    assign in_cap    = idx_x < r_cap;
    assign below_ext = idx_x < XW'(cur_ext);
    assign act       = slot_rdata[PAYLOAD_BITS];
    assign rpay      = slot_rdata[PAYLOAD_BITS-1:0];

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_i        = r_i;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        busy       = 1'b1;
        slot_we    = 1'b0;
        slot_waddr = {r_pool, idx_s};
        slot_wdata = {1'b1, r_data};
        slot_raddr = {in_pool, SW'(i_cmd.slot_index)};
        stk_we     = 1'b0;
        stk_waddr  = {r_pool, SW'(cur_top)};
        stk_wdata  = idx_s;
        stk_raddr  = {in_pool, SW'(r_free_top[in_pool] - ONE_E)};
        ext_we     = 1'b0;
        n_ext      = cur_ext;
        top_we     = 1'b0;
        n_top      = cur_top;

        case (r_state)
            ST_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                slot_wdata = '0;
                n_clr      = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_done                = 1'b1;
                n_state               = ST_IDLE;
                n_rsp.ok              = 1'b0;
                n_rsp.assigned_slot   = r_idx;
                n_rsp.payload_out     = '0;
                if (r_pool_ok) begin
                    case (r_mode)
                        MODE_ADD: begin
                            n_rsp.assigned_slot = '0;
                            if (cur_top != '0) begin
                                // reuse the newest freed slot
                                slot_we             = 1'b1;
                                slot_waddr          = {r_pool, stk_rdata};
                                top_we              = 1'b1;
                                n_top               = cur_top - ONE_E;
                                n_rsp.ok            = 1'b1;
                                n_rsp.assigned_slot = SLOT_W'(stk_rdata);
                            end else if (XW'(cur_ext) < r_cap) begin
                                slot_we             = 1'b1;
                                slot_waddr          = {r_pool, SW'(cur_ext)};
                                ext_we              = 1'b1;
                                n_ext               = cur_ext + ONE_E;
                                n_rsp.ok            = 1'b1;
                                n_rsp.assigned_slot = SLOT_W'(cur_ext);
                            end
                        end
                        MODE_REMOVE: begin
                            if (in_cap && below_ext) begin
                                n_rsp.ok = 1'b1;
                                if (act) begin
                                    slot_we    = 1'b1;
                                    slot_wdata = {1'b0, rpay};
                                    // drop the push when the stack is full
                                    if (cur_top < SLOTS_E) begin
                                        stk_we = 1'b1;
                                        top_we = 1'b1;
                                        n_top  = cur_top + ONE_E;
                                    end
                                end
                            end
                        end
                        MODE_LOOKUP: begin
                            if (in_cap && below_ext && act) begin
                                n_rsp.ok          = 1'b1;
                                n_rsp.payload_out = PAY_W'(rpay);
                            end
                        end
                        MODE_SET: begin
                            if (r_idx != '0 && in_cap) begin
                                if (act) begin
                                    slot_we  = 1'b1;
                                    n_rsp.ok = 1'b1;
                                end else if (!below_ext) begin
                                    // grow past the end, skipped slots leak
                                    slot_we  = 1'b1;
                                    ext_we   = 1'b1;
                                    n_ext    = EW'(r_idx) + ONE_E;
                                    n_rsp.ok = 1'b1;
                                end else if (cur_top != '0) begin
                                    n_done    = 1'b0;
                                    n_state   = ST_SEARCH;
                                    n_i       = '0;
                                    stk_raddr = {r_pool, SW'(0)};
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH: begin
                // stack entry r_i is on the read data; fetch the next one
                stk_raddr           = {r_pool, SW'(r_i + SW'(1))};
                n_rsp.ok            = 1'b0;
                n_rsp.assigned_slot = r_idx;
                n_rsp.payload_out   = '0;
                if (stk_rdata == idx_s) begin
                    // swap the top entry into the hole and pop
                    stk_we    = 1'b1;
                    stk_waddr = {r_pool, r_i};
                    stk_wdata = r_top_ent;
                    top_we    = 1'b1;
                    n_top     = cur_top - ONE_E;
                    slot_we   = 1'b1;
                    n_rsp.ok  = 1'b1;
                    n_done    = 1'b1;
                    n_state   = ST_IDLE;
                end else if (EW'(r_i) + ONE_E == cur_top) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_i = r_i + SW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (n_done) begin
            n_rsp.used_extent = r_pool_ok ? EXT_W'(n_ext) : EXT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_i     <= '0;
            r_done  <= 1'b0;
            for (int p = 0; p < NP; p++) begin
                r_extent[p]   <= ONE_E;
                r_free_top[p] <= '0;
            end
            for (int c = 0; c < CAP_REGS; c++) begin
                r_cap_cfg[c] <= CAP_RESET;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_i     <= n_i;
            r_done  <= n_done;
            if (ext_we) begin
                r_extent[r_pool] <= n_ext;
            end
            if (top_we) begin
                r_free_top[r_pool] <= n_top;
            end
            if (i_cfg_we) begin
                r_cap_cfg[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (start && !busy) begin
            r_mode    <= i_cmd.mode;
            r_pool    <= in_pool;
            r_pool_ok <= in_pool_ok;
            r_idx     <= i_cmd.slot_index;
            r_data    <= i_cmd.payload_in[PAYLOAD_BITS-1:0];
            r_cap     <= cap_eff;
        end
        if (r_state == ST_EXEC) begin
            r_top_ent <= stk_rdata;
        end
    end

    spa_ram #(
        .AW (AW),
        .DW (SDW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    spa_ram #(
        .AW (AW),
        .DW (SW)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == ST_EXEC || $past(r_state) == ST_SEARCH))
        else $error("result strobe without an executing command");

    a_add_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_pool_ok && r_mode == MODE_ADD && !o_rsp.ok)
            |-> o_rsp.assigned_slot == '0)
        else $error("failed add returned a nonzero slot");

    a_pool_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EXEC |-> (cur_top <= SLOTS_E && cur_ext != '0 && cur_ext <= SLOTS_E))
        else $error("free stack top or extent out of bounds");

endmodule
